[rtl/tfcc_pkg.sv]
// ----------------------------------------------------------------------------
// tfcc_pkg
// Types, constants and the CRC-8 byte update for the temperature frame check.
// ----------------------------------------------------------------------------
package tfcc_pkg;

	// Frame byte position; zero is never entered and acts as idle
	typedef enum logic [1:0] {
		POS_LOW_HELD  = 2'd1,
		POS_BOTH_HELD = 2'd2,
		POS_IDLE      = 2'd3
	} pos_t;

	// Reflected Maxim CRC-8 feedback constant
	localparam logic [7:0] CRC_FEEDBACK = 8'h18;
	localparam logic [7:0] CRC_TOP_BIT  = 8'h80;
	localparam logic [7:0] CRC_INIT     = 8'h00;

	// 25 degrees in 9.8 fixed point
	localparam logic [16:0] OFFSET_Q8 = 17'd6400;

	// One frame result
	typedef struct packed {
		logic               crc_ok;
		logic signed [15:0] raw_reading;
		logic signed [16:0] celsius_q8;
	} result_t;

	// Control status from the frame tracker
	typedef struct packed {
		logic emit;
		pos_t pos;
	} frame_status_t;

	// Eight unrolled bit steps of the reflected CRC-8
	function automatic logic [7:0] crc_byte(input logic [7:0] acc_in, input logic [7:0] data_in);
		logic [7:0] acc;
		logic [7:0] data;
		acc  = acc_in;
		data = data_in;
		for (int k = 0; k < 8; k++) begin
			if ((acc[0] ^ data[0]) == 1'b1) begin
				acc = ((acc ^ CRC_FEEDBACK) >> 1) | CRC_TOP_BIT;
			end else begin
				acc = acc >> 1;
			end
			data = data >> 1;
		end
		return acc;
	endfunction

endpackage

[rtl/tfcc_frame_ctrl.sv]
// ----------------------------------------------------------------------------
// tfcc_frame_ctrl
// Tracks the byte position of a frame, runs the CRC over the data bytes and
// forms the result when the CRC byte arrives.
// ----------------------------------------------------------------------------
module tfcc_frame_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [7:0]              byte_value,
	input  logic                    frame_first,
	input  logic                    step,
	output tfcc_pkg::frame_status_t status,
	output tfcc_pkg::result_t       result
);
	import tfcc_pkg::*;

	pos_t       pos_q;
	pos_t       pos_d;
	logic [7:0] crc_q;
	logic [7:0] low_q;
	logic [7:0] high_q;
	logic [7:0] crc_seed;
	logic [7:0] crc_next;
	logic [15:0] raw;

	// CRC restarts from zero on a first byte
	assign crc_seed = frame_first ? CRC_INIT : crc_q;
	assign crc_next = crc_byte(crc_seed, byte_value);

	// Next position
	always_comb begin
		if (frame_first) begin
			pos_d = POS_LOW_HELD;
		end else begin
			unique case (pos_q)
				POS_LOW_HELD:  pos_d = POS_BOTH_HELD;
				POS_BOTH_HELD: pos_d = POS_IDLE;
				default:       pos_d = POS_IDLE;
			endcase
		end
	end

	// Frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_IDLE;
			crc_q  <= CRC_INIT;
			low_q  <= 8'd0;
			high_q <= 8'd0;
		end else if (step) begin
			pos_q <= pos_d;
			if (frame_first) begin
				low_q <= byte_value;
				crc_q <= crc_next;
			end else if (pos_q == POS_LOW_HELD) begin
				high_q <= byte_value;
				crc_q  <= crc_next;
			end
		end
	end

	// Result for the CRC byte
	assign raw                = {high_q, low_q};
	assign status.emit        = !frame_first && (pos_q == POS_BOTH_HELD);
	assign status.pos         = pos_q;
	assign result.crc_ok      = (crc_q == byte_value);
	assign result.raw_reading = raw;
	assign result.celsius_q8  = {raw[15], raw} + OFFSET_Q8;

endmodule

[rtl/temperature_frame_crc_check_unit.sv]
// ----------------------------------------------------------------------------
// temperature_frame_crc_check_unit
// Checks three-byte sensor temperature frames against their CRC-8 and gives
// the raw reading and the temperature in signed 9.8 fixed-point degrees Celsius.
// ----------------------------------------------------------------------------
// A CRC byte passes the input register, then the result register, to m_tvalid.
// Throughput: one byte per cycle, set by the CRC byte update in the frame tracker;
// a result holds in the output register until taken, and a CRC byte waits meanwhile.
// Reset: arst_n clears the stage valids and returns the tracker to idle,
// waiting for a byte marked first.
// ----------------------------------------------------------------------------
module temperature_frame_crc_check_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] byte_value
	input  logic        s_tuser,  // [0] frame_first
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [15:0] raw_reading, [32:16] celsius_q8, rest zero
	output logic        m_tuser   // [0] crc_ok
);
	import tfcc_pkg::*;

	logic          v_s1;
	logic [7:0]    byte_s1;
	logic          first_s1;
	logic          out_free;
	logic          adv_s1;
	logic          load_out;
	frame_status_t status;
	result_t       result;
	result_t       out_q;

	tfcc_frame_ctrl u_frame_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_value (byte_s1),
		.frame_first(first_s1),
		.step       (adv_s1),
		.status     (status),
		.result     (result)
	);

	// Handshake: a byte without a result never waits on the output side
	assign out_free = !m_tvalid || m_tready;
	assign adv_s1   = v_s1 && (out_free || !status.emit);
	assign load_out = adv_s1 && status.emit;
	assign s_tready = !v_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			first_s1 <= s_tuser;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= load_out;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= result;
		end
	end

	assign m_tuser = out_q.crc_ok;
	assign m_tdata = {7'd0, out_q.celsius_q8, out_q.raw_reading};

	// A result is never loaded over one still waiting
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> out_free)
		else $error("result loaded while output occupied");

	// An empty input stage always takes a transfer
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_tready)
		else $error("input stalled with empty stage");

	// After a result the tracker is idle
	a_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (status.pos == POS_IDLE))
		else $error("tracker not idle after result");

	// Celsius field is the extended reading plus the offset
	a_celsius: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[32:16] == ({m_tdata[15], m_tdata[15:0]} + OFFSET_Q8)))
		else $error("celsius field inconsistent with reading");

endmodule

[sim/temperature_frame_crc_check_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_frame_crc_check_unit_tb
// Streams sensor frame bytes into the CRC check unit and compares every frame
// result against an independent tracker of the frame state and CRC-8.
// Runs a directed set of corner frames, then random frames, broken frames and
// noise under four traffic phases. It also holds off the result side for a
// long stretch, so that the unit backs up into its input.
// ----------------------------------------------------------------------------

// Tracks frame position and CRC-8 per accepted byte, holds expected readings
class frame_reading_tracker;
	tfcc_pkg::pos_t          position;
	logic [7:0]              crc_acc;
	logic [7:0]              low_hold;
	logic [7:0]              high_hold;
	tfcc_pkg::result_t       pending_readings[$];
	int unsigned             errors;

	function new();
		position = tfcc_pkg::POS_IDLE;
		crc_acc  = tfcc_pkg::CRC_INIT;
		low_hold = 8'h00;
		high_hold = 8'h00;
		errors   = 0;
	endfunction

	// Reflected Maxim CRC-8, byte folded in first, 0x8C per shifted-out one
	function logic [7:0] maxim_crc8_step(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] c;
		c = acc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ 8'h8C;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// Accepted input byte; returns 0 when the unit ignores it
	function bit take_byte(input logic [7:0] b, input logic first);
		tfcc_pkg::result_t r;
		if (first) begin
			low_hold = b;
			crc_acc  = maxim_crc8_step(tfcc_pkg::CRC_INIT, b);
			position = tfcc_pkg::POS_LOW_HELD;
			return 1'b1;
		end
		case (position)
			tfcc_pkg::POS_LOW_HELD: begin
				high_hold = b;
				crc_acc   = maxim_crc8_step(crc_acc, b);
				position  = tfcc_pkg::POS_BOTH_HELD;
				return 1'b1;
			end
			tfcc_pkg::POS_BOTH_HELD: begin
				position      = tfcc_pkg::POS_IDLE;
				r.crc_ok      = (crc_acc == b);
				r.raw_reading = {high_hold, low_hold};
				r.celsius_q8  = {high_hold[7], high_hold, low_hold} + tfcc_pkg::OFFSET_Q8;
				pending_readings.push_back(r);
				return 1'b1;
			end
			default: begin
				position = tfcc_pkg::POS_IDLE;
				return 1'b0;
			end
		endcase
	endfunction

	function void note_error(input string what);
		errors++;
		if (errors <= 10) begin
			$display("mismatch: %s", what);
		end
	endfunction

	// Result transfer against the oldest expected reading
	function void compare_reading(input logic [39:0] data, input logic user);
		tfcc_pkg::result_t r;
		if (pending_readings.size() == 0) begin
			note_error($sformatf("unexpected result tdata=%h tuser=%b", data, user));
			return;
		end
		r = pending_readings.pop_front();
		if (user !== r.crc_ok) begin
			note_error($sformatf("crc_ok exp %b got %b", r.crc_ok, user));
		end
		if (data[15:0] !== r.raw_reading) begin
			note_error($sformatf("raw_reading exp %h got %h", r.raw_reading, data[15:0]));
		end
		if (data[32:16] !== r.celsius_q8) begin
			note_error($sformatf("celsius_q8 exp %h got %h", r.celsius_q8, data[32:16]));
		end
		if (data[39:33] !== 7'd0) begin
			note_error($sformatf("tdata pad exp 0 got %h", data[39:33]));
		end
	endfunction

	function int unsigned pending();
		return pending_readings.size();
	endfunction
endclass

module temperature_frame_crc_check_unit_tb;
	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] byte_value
	logic        s_tuser;   // [0] frame_first
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [15:0] raw_reading, [32:16] celsius_q8, rest zero
	logic        m_tuser;   // [0] crc_ok

	frame_reading_tracker ledger;
	int unsigned          send_idle_pct;
	int unsigned          recv_stall_pct;
	int unsigned          bytes_used;
	bit                   hold_req;
	int unsigned          hold_left;

	temperature_frame_crc_check_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit
	initial begin
		#4_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Result side: check transfers, stall at random, long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				ledger.compare_reading(m_tdata, m_tuser);
			end
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = 250;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// One byte transfer, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b, input logic first);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= first;
		forever begin
			@(posedge clk);
			if (s_tready) break;
		end
		if (ledger.take_byte(b, first)) bytes_used++;
	endtask

	// Complete frame; a bad CRC byte differs from the right one
	task automatic send_frame(input logic [7:0] lo, input logic [7:0] hi, input bit good);
		logic [7:0] crc;
		crc = ledger.maxim_crc8_step(ledger.maxim_crc8_step(tfcc_pkg::CRC_INIT, lo), hi);
		if (!good) crc ^= 8'($urandom_range(1, 255));
		send_byte(lo, 1'b1);
		send_byte(hi, 1'b0);
		send_byte(crc, 1'b0);
	endtask

	// Random byte leaning on the extremes
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 19))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h80;
			3:       return 8'h7F;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		int unsigned target;
		int unsigned r;
		ledger         = new();
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = 8'h00;
		s_tuser        = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		bytes_used     = 0;
		hold_req       = 1'b0;
		hold_left      = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners
		send_byte(8'hA5, 1'b0);            // unflagged while idle
		send_frame(8'h00, 8'h00, 1'b1);
		send_frame(8'hFF, 8'h7F, 1'b1);    // most positive reading
		send_frame(8'h00, 8'h80, 1'b0);    // most negative, CRC mismatch
		send_frame(8'hFF, 8'hFF, 1'b1);
		send_byte(8'h55, 1'b0);            // trailing byte after CRC
		send_byte(8'h12, 1'b1);            // restart after the low byte
		send_frame(8'h34, 8'h56, 1'b1);
		send_byte(8'h11, 1'b1);            // restart at the CRC position
		send_byte(8'h22, 1'b0);
		send_frame(8'h33, 8'h44, 1'b1);

		// Random traffic, one idling profile per phase
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_req = 1'b1; end
				1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			target = bytes_used + 475;
			while (bytes_used < target) begin
				r = $urandom_range(0, 99);
				if (r < 75) begin
					send_frame(pick_byte(), pick_byte(), $urandom_range(0, 99) < 85);
					if ($urandom_range(0, 99) < 15) begin
						repeat ($urandom_range(1, 2)) send_byte(pick_byte(), 1'b0);
					end
				end else if (r < 88) begin
					// cut-off frame, the next one restarts it
					send_byte(pick_byte(), 1'b1);
					if ($urandom_range(0, 1)) send_byte(pick_byte(), 1'b0);
				end else begin
					send_byte(pick_byte(), 1'($urandom_range(0, 1)));
				end
			end
		end

		// Drain
		s_tvalid <= 1'b0;
		recv_stall_pct = 0;
		while (ledger.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (ledger.errors == 0 && ledger.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

[temperature_frame_crc_check_unit.f]
rtl/tfcc_pkg.sv
rtl/tfcc_frame_ctrl.sv
rtl/temperature_frame_crc_check_unit.sv
sim/temperature_frame_crc_check_unit_tb.sv
